### rtl/iseq_pkg.sv
// Shared constants, codes, types and status-byte helper for the status and error queue.
package iseq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int CMD_W  = 4;
  localparam int FORM_W = 2;
  localparam int VAL_W  = 8;
  localparam int EIDX_W = 5;
  localparam int BIT_W  = 3;
  localparam int KIND_W = 3;
  localparam int LIM_W  = 5;

  localparam logic [LIM_W-1:0] LIM_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_OPC,
    CMD_ESE,
    CMD_SRE,
    CMD_CLS,
    CMD_RST,
    CMD_IDN,
    CMD_ESR,
    CMD_STB,
    CMD_TST,
    CMD_ERR1,
    CMD_ERRCOUNT,
    CMD_ERRALL,
    CMD_POST,
    CMD_SETBIT
  } cmd_t;

  typedef enum logic [FORM_W-1:0] {
    FORM_SET,
    FORM_PARAM,
    FORM_QUERY,
    FORM_BAD
  } form_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_REG,
    KIND_ERR,
    KIND_COUNT,
    KIND_IDN,
    KIND_TST,
    KIND_SRQ
  } kind_t;

  localparam logic [EIDX_W-1:0] ERR_NONE     = 5'd0;
  localparam logic [EIDX_W-1:0] ERR_COMMAND  = 5'd1;
  localparam logic [EIDX_W-1:0] ERR_NUMERIC  = 5'd6;
  localparam logic [EIDX_W-1:0] ERR_OVERFLOW = 5'd14;
  localparam logic [EIDX_W-1:0] ERR_QUERY    = 5'd15;
  localparam logic [EIDX_W-1:0] ERR_MAXIDX   = 5'd16;

  // Status byte and event status masks.
  localparam logic [VAL_W-1:0] QNE_MASK    = 8'h04;
  localparam logic [VAL_W-1:0] ESB_MASK    = 8'h20;
  localparam logic [VAL_W-1:0] RQS_MASK    = 8'h40;
  localparam logic [VAL_W-1:0] SUMMARY_MSK = 8'hBF;
  localparam logic [VAL_W-1:0] ES_OPC_MASK = 8'h01;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT,
    ST_RD,
    ST_POP
  } st_t;

  typedef struct packed {
    kind_t              kind;
    logic [VAL_W-1:0]   value;
    logic [EIDX_W-1:0]  error_index;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [VAL_W-1:0] sb;
    logic             srq;
  } stb_t;

  // Writes the status byte: any enabled summary bit raises RQS, and a service
  // request is reported when the enable also has RQS set.
  function automatic stb_t stb_write(logic [VAL_W-1:0] b, logic [VAL_W-1:0] se);
    stb_t r;
    r.sb  = b;
    r.srq = 1'b0;
    if ((b & se & SUMMARY_MSK) != '0) begin
      r.sb  = b | RQS_MASK;
      r.srq = ((se & RQS_MASK) != '0);
    end
    return r;
  endfunction

endpackage

### rtl/iseq_if.sv
// Channel interfaces: command input, result output and limit configuration.
interface iseq_in_if;
  import iseq_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [FORM_W-1:0] form;
  logic              param_ok;
  logic [VAL_W-1:0]  param_value;
  logic              op_complete;
  logic [EIDX_W-1:0] error_code;
  logic [BIT_W-1:0]  status_bit;

  modport source (
    output valid, command, form, param_ok, param_value, op_complete, error_code,
           status_bit,
    input  ready
  );
  modport sink (
    input  valid, command, form, param_ok, param_value, op_complete, error_code,
           status_bit,
    output ready
  );
endinterface

interface iseq_out_if;
  import iseq_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [VAL_W-1:0]  value;
  logic [EIDX_W-1:0] error_index;
  logic              last;

  modport source (output valid, result_kind, value, error_index, last, input ready);
  modport sink (input valid, result_kind, value, error_index, last, output ready);
endinterface

interface iseq_cfg_if;
  import iseq_pkg::*;
  logic             valid;
  logic             ready;
  logic [LIM_W-1:0] error_queue_limit;

  modport source (output valid, error_queue_limit, input ready);
  modport sink (input valid, error_queue_limit, output ready);
endinterface

### rtl/iseq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module iseq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/iseq_obuf.sv
// Output holding register that decouples result production from the sink.
module iseq_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  iseq_pkg::res_t    res,
  output logic              free,
  iseq_out_if.source        out_ch
);
  import iseq_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t data_r;

  assign free      = !valid_r || out_ch.ready;
  assign valid_nxt = load || (valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.result_kind = data_r.kind;
  assign out_ch.value       = data_r.value;
  assign out_ch.error_index = data_r.error_index;
  assign out_ch.last        = data_r.last;

endmodule

### rtl/iseq_ctrl.sv
// Command sequencer: status registers, error queue pointers and queue walk.
module iseq_ctrl #(
  parameter int QUEUE_DEPTH = iseq_pkg::QUEUE_DEPTH_DEF,
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  iseq_in_if.sink                     in_ch,
  iseq_cfg_if.sink                    cfg_ch,
  output logic                        ram_we,
  output logic [IDX_W-1:0]            ram_waddr,
  output logic [iseq_pkg::EIDX_W-1:0] ram_wdata,
  output logic                        ram_re,
  output logic [IDX_W-1:0]            ram_raddr,
  input  logic [iseq_pkg::EIDX_W-1:0] ram_rdata,
  input  logic                        out_free,
  output logic                        out_load,
  output iseq_pkg::res_t              out_res
);
  import iseq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;

  st_t state_r, state_nxt;

  logic [LIM_W-1:0] limit_r;
  logic [VAL_W-1:0] sb_r, se_r, es_r, ee_r;
  logic [VAL_W-1:0] sb_nxt, se_nxt, es_nxt, ee_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             walk_r, all_r;
  res_t             pend_r;

  logic [CMD_W-1:0]  cmd_r;
  logic [FORM_W-1:0] form_r;
  logic              pok_r;
  logic [VAL_W-1:0]  pval_r;
  logic              opc_r;
  logic [EIDX_W-1:0] ecode_r;
  logic [BIT_W-1:0]  sbit_r;

  logic              accept;
  logic              srq_nxt;
  logic              post;
  logic [EIDX_W-1:0] post_code;
  logic              reply;
  res_t              reply_res;
  logic              pop;
  logic              pop_all;
  logic              clear;
  stb_t              st;

  logic [LIM_W-1:0]  lim_eff;
  logic              full;
  logic [SUM_W-1:0]  pos_raw;
  logic [SUM_W-1:0]  pos_wrap;
  logic [IDX_W-1:0]  head_inc;
  logic              walk_done;

  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign walk_done    = !all_r || (cnt_r == '0);

  // Decode of the held command into new register values and actions.
  always_comb begin
    se_nxt    = se_r;
    es_nxt    = es_r;
    ee_nxt    = ee_r;
    post      = 1'b0;
    post_code = ERR_COMMAND;
    reply     = 1'b0;
    reply_res = '{kind: KIND_REG, value: '0, error_index: ERR_NONE, last: 1'b1};
    pop       = 1'b0;
    pop_all   = 1'b0;
    clear     = 1'b0;
    st        = '{sb: sb_r, srq: 1'b0};
    unique case (cmd_t'(cmd_r))
      CMD_OPC: begin
        if (form_t'(form_r) == FORM_SET) begin
          es_nxt = es_r | ES_OPC_MASK;
          if ((es_nxt & ee_r) != '0) begin
            st = stb_write(sb_r | ESB_MASK, se_r);
          end
        end else if (form_t'(form_r) == FORM_QUERY) begin
          reply           = 1'b1;
          reply_res.value = {{(VAL_W-1){1'b0}}, opc_r};
        end else begin
          post = 1'b1;
        end
      end
      CMD_ESE, CMD_SRE: begin
        if (form_t'(form_r) == FORM_PARAM) begin
          if (pok_r) begin
            if (cmd_t'(cmd_r) == CMD_ESE) begin
              ee_nxt = pval_r;
              if ((es_r & pval_r) != '0) begin
                st = stb_write(sb_r | ESB_MASK, se_r);
              end
            end else begin
              se_nxt = pval_r;
              st     = stb_write(sb_r, pval_r);
            end
          end else begin
            post      = 1'b1;
            post_code = ERR_NUMERIC;
          end
        end else if (form_t'(form_r) == FORM_QUERY) begin
          reply           = 1'b1;
          reply_res.value = (cmd_t'(cmd_r) == CMD_ESE) ? ee_r : se_r;
        end else begin
          post = 1'b1;
        end
      end
      CMD_CLS, CMD_RST: begin
        if (form_t'(form_r) == FORM_SET) begin
          // A clear wipes the event status, the status byte and the queue.
          if (cmd_t'(cmd_r) == CMD_CLS) begin
            clear  = 1'b1;
            es_nxt = '0;
            st.sb  = '0;
          end
        end else if (form_t'(form_r) == FORM_QUERY) begin
          post      = 1'b1;
          post_code = ERR_QUERY;
        end else begin
          post = 1'b1;
        end
      end
      CMD_IDN, CMD_ESR, CMD_STB, CMD_TST, CMD_ERR1, CMD_ERRCOUNT, CMD_ERRALL: begin
        if (form_t'(form_r) != FORM_QUERY) begin
          post = 1'b1;
        end else begin
          unique case (cmd_t'(cmd_r))
            CMD_IDN: begin
              reply          = 1'b1;
              reply_res.kind = KIND_IDN;
            end
            CMD_ESR: begin
              reply           = 1'b1;
              reply_res.value = es_r;
            end
            CMD_STB: begin
              reply           = 1'b1;
              reply_res.value = sb_r;
            end
            CMD_TST: begin
              reply          = 1'b1;
              reply_res.kind = KIND_TST;
            end
            CMD_ERRCOUNT: begin
              reply           = 1'b1;
              reply_res.kind  = KIND_COUNT;
              reply_res.value = VAL_W'(cnt_r);
            end
            default: begin
              if (cnt_r == '0) begin
                reply          = 1'b1;
                reply_res.kind = KIND_ERR;
              end else begin
                pop     = 1'b1;
                pop_all = (cmd_t'(cmd_r) == CMD_ERRALL);
                // The pop that empties the queue clears queue-not-empty; the
                // request it may raise comes before any entry.
                if (pop_all || (cnt_r == CNT_W'(1))) begin
                  st = stb_write(sb_r & ~QNE_MASK, se_r);
                end
              end
            end
          endcase
        end
      end
      CMD_POST: begin
        post      = 1'b1;
        post_code = (ecode_r > ERR_MAXIDX) ? ERR_MAXIDX : ecode_r;
      end
      CMD_SETBIT: begin
        st = stb_write(sb_r | (8'h01 << sbit_r), se_r);
      end
      default: begin
      end
    endcase
    if (post) begin
      st = stb_write(sb_r | QNE_MASK, se_r);
    end
    sb_nxt  = st.sb;
    srq_nxt = st.srq;
  end

  // Queue slot arithmetic; head plus count stays below twice the depth.
  always_comb begin
    lim_eff  = (limit_r == '0) ? LIM_W'(1) : limit_r;
    full     = (CMP_W'(cnt_r) >= CMP_W'(lim_eff)) || (cnt_r == CNT_W'(QUEUE_DEPTH));
    pos_raw  = SUM_W'(head_r) + SUM_W'(cnt_r) - (full ? SUM_W'(1) : SUM_W'(0));
    pos_wrap = (pos_raw >= SUM_W'(QUEUE_DEPTH)) ? (pos_raw - SUM_W'(QUEUE_DEPTH)) : pos_raw;
    head_inc = (head_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : (head_r + IDX_W'(1));
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (pop) begin
          state_nxt = srq_nxt ? ST_EMIT : ST_RD;
        end else if (reply || srq_nxt) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = walk_r ? ST_RD : ST_IDLE;
        end
      end
      ST_RD: begin
        state_nxt = ST_POP;
      end
      ST_POP: begin
        if (out_free && walk_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State outputs. While an entry is handed over, the next read is issued so
  // that a full walk moves one entry per cycle while the output register is free.
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    out_load    = ((state_r == ST_EMIT) || (state_r == ST_POP)) && out_free;
    out_res     = pend_r;
    if (state_r == ST_POP) begin
      out_res = '{kind: KIND_ERR, value: '0, error_index: ram_rdata, last: walk_done};
    end
    ram_re    = (state_r == ST_RD) || ((state_r == ST_POP) && out_free && !walk_done);
    ram_raddr = head_r;
    ram_we    = (state_r == ST_EXEC) && post;
    ram_waddr = pos_wrap[IDX_W-1:0];
    ram_wdata = full ? ERR_OVERFLOW : post_code;
  end

  always_comb begin
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    if (state_r == ST_EXEC) begin
      if (clear) begin
        head_nxt = '0;
        cnt_nxt  = '0;
      end else if (post && !full) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
    if (ram_re) begin
      head_nxt = head_inc;
      cnt_nxt  = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      limit_r <= LIM_RESET;
      sb_r    <= '0;
      se_r    <= '0;
      es_r    <= '0;
      ee_r    <= '0;
      head_r  <= '0;
      cnt_r   <= '0;
      walk_r  <= 1'b0;
      all_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_ch.valid) begin
        limit_r <= cfg_ch.error_queue_limit;
      end
      if (state_r == ST_EXEC) begin
        sb_r   <= sb_nxt;
        se_r   <= se_nxt;
        es_r   <= es_nxt;
        ee_r   <= ee_nxt;
        walk_r <= pop;
        all_r  <= pop_all;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_ch.command;
      form_r  <= in_ch.form;
      pok_r   <= in_ch.param_ok;
      pval_r  <= in_ch.param_value;
      opc_r   <= in_ch.op_complete;
      ecode_r <= in_ch.error_code;
      sbit_r  <= in_ch.status_bit;
    end
    if (state_r == ST_EXEC) begin
      if (reply) begin
        pend_r <= reply_res;
      end else begin
        pend_r <= '{kind: KIND_SRQ, value: sb_nxt, error_index: ERR_NONE, last: !pop};
      end
    end
  end

endmodule

### rtl/instrument_status_and_error_queue.sv
// Top level of the status reporting block with its bounded error queue.
//
//   channel  | dir | payload                                                 | transfer
//   in_ch    | in  | command, form, param_ok, param_value, op_complete,      | valid & ready
//            |     | error_code, status_bit                                  |
//   out_ch   | out | result_kind, value, error_index, last                   | valid & ready
//   cfg_ch   | in  | error_queue_limit                                       | valid & ready
//
// An item is accepted, then executed, then hands each result to the output
// register; a queue walk adds a read state, then moves one entry per cycle
// through the error RAM's single read port while the sink keeps up, with a
// service request, if any, going out before the first entry. Reset (rst_n
// low, synchronous) clears the status registers and empties the queue; the
// error RAM needs no clearing. A stalled result sink holds the sequencer at
// its next result; cfg_ch is always ready.
module instrument_status_and_error_queue #(
  parameter int QUEUE_DEPTH = iseq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  iseq_in_if.sink     in_ch,
  iseq_out_if.source  out_ch,
  iseq_cfg_if.sink    cfg_ch
);
  import iseq_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [EIDX_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [EIDX_W-1:0] ram_rdata;
  logic              out_free;
  logic              out_load;
  res_t              out_res;

  iseq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_free  (out_free),
    .out_load  (out_load),
    .out_res   (out_res)
  );

  iseq_ram #(
    .WIDTH (EIDX_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_err_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  iseq_obuf u_obuf (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (out_load),
    .res    (out_res),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

### rtl/iseq_checker.sv
// Port-level checks for the status and error queue, bound to the top level.
module iseq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [iseq_pkg::KIND_W-1:0] out_kind,
  input logic [iseq_pkg::VAL_W-1:0]  out_value,
  input logic [iseq_pkg::EIDX_W-1:0] out_eidx,
  input logic                        out_last
);
  import iseq_pkg::*;

  // An accepted command is executed before another one is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on two consecutive edges");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_kind) && $stable(out_value) && $stable(out_eidx)
       && $stable(out_last)))
    else $error("stalled result changed");

  // A service request always reports a status byte with RQS set.
  a_srq_rqs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_SRQ)) |-> ((out_value & RQS_MASK) != '0))
    else $error("service request without RQS in the status byte");

  a_eidx_only_entries: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind != KIND_ERR)) |-> (out_eidx == ERR_NONE))
    else $error("error index on a result that is not an error entry");

endmodule

bind instrument_status_and_error_queue iseq_checker u_iseq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.result_kind),
  .out_value (out_ch.value),
  .out_eidx  (out_ch.error_index),
  .out_last  (out_ch.last)
);
